@@ sv/bdlp_pkg.sv @@
// Shared types and constants for the button debounce and long-press block.
package bdlp_pkg;

    localparam int RAW_W     = 4;
    localparam int IDXF_W    = 4;
    localparam int LEVELS_W  = 4;
    localparam int LIMIT_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd300;
    localparam logic               LEVEL_RESET = 1'b0;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_RC_PRESS   = 3'd1,
        OP_RC_LREL    = 3'd2,
        OP_READ_LEVEL = 3'd3,
        OP_READ_HELD  = 3'd4
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_PRESS_TICKS = 1'd0,
        CFG_PRESSED_LEVEL    = 1'd1
    } t_cfg_index;

    typedef struct packed {
        logic stable;
        logic press;
        logic lrel;
        logic held;
    } t_lane_status;

endpackage

@@ sv/bdlp_lane.sv @@
// Per-button sample history, debounced level, hold counter and event flags.
module bdlp_lane (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_tick,
    input  logic                            i_pressed,
    input  logic [bdlp_pkg::LIMIT_W-1:0]    i_limit,
    input  logic                            i_clr_press,
    input  logic                            i_clr_lrel,
    output bdlp_pkg::t_lane_status          o_status,
    output logic                            o_stable_next
);

    logic                           r_sn, r_sm, r_stable, r_press, r_lrel, r_held;
    logic                           n_sn, n_sm, n_stable, n_press, n_lrel, n_held;
    logic [bdlp_pkg::LIMIT_W-1:0]   r_cnt, n_cnt;
    logic                           agree;

    // the incoming sample, r_sn and r_sm are the newest, middle and oldest
    // samples before the shift
    always_comb begin
        n_sn     = r_sn;
        n_sm     = r_sm;
        n_stable = r_stable;
        n_press  = r_press;
        n_lrel   = r_lrel;
        n_held   = r_held;
        n_cnt    = r_cnt;
        agree    = (i_pressed == r_sn) && (i_pressed == r_sm);
        if (i_tick) begin
            n_sm     = r_sn;
            n_sn     = i_pressed;
            n_press  = r_press | (agree & i_pressed & ~r_stable);
            n_stable = agree ? i_pressed : r_stable;
            if (n_stable) begin
                if (r_cnt < i_limit) begin
                    n_cnt = r_cnt + bdlp_pkg::LIMIT_W'(1);
                end else begin
                    n_held = 1'b1;
                end
            end else begin
                n_lrel  = r_held;
                n_press = 1'b0;
                n_cnt   = '0;
                n_held  = 1'b0;
            end
        end
        if (i_clr_press) begin
            n_press = 1'b0;
        end
        if (i_clr_lrel) begin
            n_lrel = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sn     <= 1'b0;
            r_sm     <= 1'b0;
            r_stable <= 1'b0;
            r_press  <= 1'b0;
            r_lrel   <= 1'b0;
            r_held   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_sn     <= n_sn;
            r_sm     <= n_sm;
            r_stable <= n_stable;
            r_press  <= n_press;
            r_lrel   <= n_lrel;
            r_held   <= n_held;
            r_cnt    <= n_cnt;
        end
    end

    assign o_status.stable = r_stable;
    assign o_status.press  = r_press;
    assign o_status.lrel   = r_lrel;
    assign o_status.held   = r_held;
    assign o_stable_next   = n_stable;

    a_held_needs_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> r_stable) else $error("long-held set on a released button");
    a_press_needs_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_press |-> r_stable) else $error("press pending on a released button");

endmodule

@@ sv/button_debounce_long_press.sv @@
// Multi-button three-sample debouncer with long-press detection and query interface.
//
// Input channel (i_in_valid / o_in_ready) carries one transaction per item: an
// opcode, the raw pin levels (used by a tick) and a button index (used by queries).
// Output channel (o_out_valid / i_out_ready) returns one result per item: the
// query answer, an invalid-index mark and the debounced level of buttons 0 to 3.
// State updates at the accepting edge; the result sits in an output register and
// is valid the next cycle; throughput is one item per cycle while the receiver
// does not stall. The single output register sets this rate: a new item is
// taken when the register is empty or is being emptied in the same cycle.
// When the receiver stalls, the result holds and o_in_ready drops until it is
// taken. Reset (synchronous, active low) clears all sample, level, flag and
// counter state, sets long_press_ticks to 300 and pressed_level to 0 (active
// low), and empties the output register. Configuration writes through
// i_cfg_we / i_cfg_index / i_cfg_data take effect at the next edge.
module button_debounce_long_press #(
    parameter int BUTTON_COUNT = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [2:0]                          i_opcode,
    input  logic [bdlp_pkg::RAW_W-1:0]          i_raw_levels,
    input  logic [bdlp_pkg::IDXF_W-1:0]         i_button_index,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_answer,
    output logic                                o_index_invalid,
    output logic [bdlp_pkg::LEVELS_W-1:0]       o_debounced_levels,
    input  logic                                i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bdlp_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam int PAD_N = 2 ** IDX_W;

    logic [bdlp_pkg::LIMIT_W-1:0]   r_limit;
    logic                           r_level;
    logic                           r_out_valid;
    logic                           r_answer, n_answer;
    logic                           r_invalid, n_invalid;
    logic [bdlp_pkg::LEVELS_W-1:0]  r_levels, n_levels;

    logic                           accept;
    logic                           idx_ok;
    logic [IDX_W-1:0]               sel;
    logic                           is_tick, is_rc_press, is_rc_lrel;
    logic [PAD_N-1:0]               v_stable, v_press, v_lrel, v_held;
    logic [BUTTON_COUNT-1:0]        stable_next;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign idx_ok     = {1'b0, i_button_index} < 5'(BUTTON_COUNT);
    assign sel        = i_button_index[IDX_W-1:0];

    always_comb begin
        is_tick     = 1'b0;
        is_rc_press = 1'b0;
        is_rc_lrel  = 1'b0;
        n_answer    = 1'b0;
        n_invalid   = 1'b0;
        case (i_opcode)
            bdlp_pkg::OP_TICK: begin
                is_tick = 1'b1;
            end
            bdlp_pkg::OP_RC_PRESS: begin
                is_rc_press = idx_ok;
                n_answer    = idx_ok && v_press[sel];
                n_invalid   = !idx_ok;
            end
            bdlp_pkg::OP_RC_LREL: begin
                is_rc_lrel = idx_ok;
                n_answer   = idx_ok && v_lrel[sel];
                n_invalid  = !idx_ok;
            end
            bdlp_pkg::OP_READ_LEVEL: begin
                n_answer  = idx_ok && v_stable[sel];
                n_invalid = !idx_ok;
            end
            bdlp_pkg::OP_READ_HELD: begin
                n_answer  = idx_ok && v_held[sel];
                n_invalid = !idx_ok;
            end
            default: begin
                n_answer  = 1'b0;
                n_invalid = 1'b0;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < PAD_N; g++) begin : g_lane
            if (g < BUTTON_COUNT) begin : g_used
                logic                   raw_bit;
                bdlp_pkg::t_lane_status status;
                if (g < bdlp_pkg::RAW_W) begin : g_raw
                    assign raw_bit = i_raw_levels[g];
                end else begin : g_noraw
                    assign raw_bit = 1'b0;
                end
                bdlp_lane u_lane (
                    .i_clk         (i_clk),
                    .i_rst_n       (i_rst_n),
                    .i_tick        (accept && is_tick),
                    .i_pressed     (~(raw_bit ^ r_level)),
                    .i_limit       (r_limit),
                    .i_clr_press   (accept && is_rc_press && (sel == IDX_W'(g))),
                    .i_clr_lrel    (accept && is_rc_lrel && (sel == IDX_W'(g))),
                    .o_status      (status),
                    .o_stable_next (stable_next[g])
                );
                assign v_stable[g] = status.stable;
                assign v_press[g]  = status.press;
                assign v_lrel[g]   = status.lrel;
                assign v_held[g]   = status.held;
            end else begin : g_pad
                assign v_stable[g] = 1'b0;
                assign v_press[g]  = 1'b0;
                assign v_lrel[g]   = 1'b0;
                assign v_held[g]   = 1'b0;
            end
        end
        for (g = 0; g < bdlp_pkg::LEVELS_W; g++) begin : g_lvl
            if (g < BUTTON_COUNT) begin : g_on
                assign n_levels[g] = stable_next[g];
            end else begin : g_off
                assign n_levels[g] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= bdlp_pkg::LIMIT_RESET;
            r_level     <= bdlp_pkg::LEVEL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bdlp_pkg::CFG_LONG_PRESS_TICKS: r_limit <= i_cfg_data;
                    bdlp_pkg::CFG_PRESSED_LEVEL:    r_level <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_answer  <= n_answer;
            r_invalid <= n_invalid;
            r_levels  <= n_levels;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_answer           = r_answer;
    assign o_index_invalid    = r_invalid;
    assign o_debounced_levels = r_levels;

    a_no_answer_on_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_answer && r_invalid))
        else $error("answer raised together with invalid index");
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("transaction taken while result stalled");
    a_accept_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted transaction produced no result");
    a_tick_answer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_tick) |=> (!r_answer && !r_invalid))
        else $error("tick produced a nonzero answer");

endmodule
